/* sv/linear_probe_hash_dictionary_assert.svh */
// Assertion macros used by the checker file of the dictionary.
`ifndef LINEAR_PROBE_HASH_DICTIONARY_ASSERT_SVH
`define LINEAR_PROBE_HASH_DICTIONARY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPHD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dictionary check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define LPHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dictionary check failed: next-cycle implication");

`endif

/* sv/lphd_pkg.sv */
// Shared constants, codes and types of the linear probing dictionary.
package lphd_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_SIZE       = 511;
  localparam int unsigned SIZE_W         = 9;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned HASH_W         = 16;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;
  // Front register, queue entries, back engine and output register.
  localparam int unsigned MAX_INFLIGHT   = QUEUE_DEPTH + 3;

  localparam logic [KEY_W-1:0]  MIX_SEED  = 32'h876A_E319;
  localparam logic [HASH_W-1:0] FOLD_MASK = 16'hFFFF;
  localparam logic [HASH_W-1:0] MUL_A     = 16'd251;
  localparam logic [HASH_W-1:0] MUL_B     = 16'd65521;
  localparam logic [HASH_W-1:0] MUL_C     = 16'd4099;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd256;

  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ACCESS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_TABLE_SIZE    = 2'd0,
    REG_WRITE_ALLOWED = 2'd1,
    REG_READ_ALLOWED  = 2'd2
  } reg_idx_e;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              write_allowed;
    logic              read_allowed;
  } cfg_t;

  // One classified item travelling from the front end to the back end.
  typedef struct packed {
    action_e            action;
    logic               refused;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [SIZE_W-1:0]  home;
  } qent_t;

endpackage

/* sv/lphd_if.sv */
// Request and response channel interfaces of the dictionary.
interface lphd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [lphd_pkg::KEY_W-1:0]   key;
  logic [lphd_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, action, key, value_in, input ready);
  modport sink (input valid, action, key, value_in, output ready);
  modport monitor (input valid, ready, action, key, value_in);
endinterface

interface lphd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [lphd_pkg::VALUE_W-1:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
  modport monitor (input valid, ready, status, value_out);
endinterface

/* sv/lphd_front.sv */
// Front end: accepts items, checks access rights, hashes the key and reduces it to a home slot.
module lphd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lphd_pkg::cfg_t  cfg_i,
  lphd_in_if.sink         req_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output lphd_pkg::qent_t push_data_o
);

  localparam int unsigned HALF_W = lphd_pkg::HASH_W / 2;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_MUL3,
    F_MOD_HI,
    F_MOD_LO,
    F_PUSH
  } fstate_e;

  fstate_e                       state_q;
  lphd_pkg::qent_t               ent_q;
  logic [lphd_pkg::HASH_W-1:0]   r_q;
  logic                          accept;
  logic                          refused_in;

  // Fold the high half of a word onto its low half.
  function automatic logic [lphd_pkg::HASH_W-1:0] fold16(
    input logic [2*lphd_pkg::HASH_W-1:0] w
  );
    return w[2*lphd_pkg::HASH_W-1:lphd_pkg::HASH_W] ^
           (w[lphd_pkg::HASH_W-1:0] & lphd_pkg::FOLD_MASK);
  endfunction

  // One mixing round: r ^= r * m, then fold.
  function automatic logic [lphd_pkg::HASH_W-1:0] mix_round(
    input logic [lphd_pkg::HASH_W-1:0] r,
    input logic [lphd_pkg::HASH_W-1:0] m
  );
    logic [2*lphd_pkg::HASH_W-1:0] p;
    p = (2*lphd_pkg::HASH_W)'(r) * (2*lphd_pkg::HASH_W)'(m);
    return fold16(p ^ (2*lphd_pkg::HASH_W)'(r));
  endfunction

  // Eight restoring remainder steps, one dividend bit each.
  function automatic logic [lphd_pkg::SIZE_W-1:0] mod_half(
    input logic [lphd_pkg::SIZE_W-1:0] rem,
    input logic [HALF_W-1:0]           bits,
    input logic [lphd_pkg::SIZE_W-1:0] d
  );
    logic [lphd_pkg::SIZE_W:0]   t;
    logic [lphd_pkg::SIZE_W-1:0] acc;
    acc = rem;
    for (int i = HALF_W - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[lphd_pkg::SIZE_W-1:0];
    end
    return acc;
  endfunction

  // A new item is taken when idle or while the finished one leaves for the queue.
  assign req_i.ready  = (state_q == F_IDLE) || ((state_q == F_PUSH) && push_ready_i);
  assign accept       = req_i.valid && req_i.ready;
  assign refused_in   = (lphd_pkg::action_e'(req_i.action) == lphd_pkg::ACT_PUT) ?
                        !cfg_i.write_allowed : !cfg_i.read_allowed;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = ent_q;

  // Hash and modulo sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE, F_PUSH: begin
          if (accept) begin
            ent_q.action  <= lphd_pkg::action_e'(req_i.action);
            ent_q.refused <= refused_in;
            ent_q.key     <= req_i.key;
            ent_q.value   <= req_i.value_in;
            ent_q.home    <= '0;
            r_q           <= fold16(req_i.key ^ lphd_pkg::MIX_SEED);
            state_q       <= refused_in ? F_PUSH : F_MUL1;
          end else if ((state_q == F_PUSH) && push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        F_MUL1: begin
          r_q     <= mix_round(r_q, lphd_pkg::MUL_A);
          state_q <= F_MUL2;
        end
        F_MUL2: begin
          r_q     <= mix_round(r_q, lphd_pkg::MUL_B);
          state_q <= F_MUL3;
        end
        F_MUL3: begin
          r_q     <= mix_round(r_q, lphd_pkg::MUL_C);
          state_q <= F_MOD_HI;
        end
        F_MOD_HI: begin
          ent_q.home <= mod_half('0, r_q[lphd_pkg::HASH_W-1:HALF_W], cfg_i.size);
          state_q    <= F_MOD_LO;
        end
        F_MOD_LO: begin
          ent_q.home <= mod_half(ent_q.home, r_q[HALF_W-1:0], cfg_i.size);
          state_q    <= F_PUSH;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/lphd_queue.sv */
// Short queue of classified items between the front end and the back end.
module lphd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lphd_pkg::qent_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lphd_pkg::qent_t pop_data_o
);

  localparam int unsigned DEPTH = lphd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  lphd_pkg::qent_t  entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/lphd_back.sv */
// Back end: probes the slot store, performs puts and gets and holds the result item.
module lphd_back #(
  parameter int unsigned CAPACITY   = lphd_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = lphd_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lphd_pkg::SIZE_W-1:0] size_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  lphd_pkg::qent_t             pop_data_i,
  lphd_out_if.source                  rsp_o
);

  localparam int unsigned SIZE_W = lphd_pkg::SIZE_W;
  localparam int unsigned DEPTH  = (CAPACITY > lphd_pkg::MAX_SIZE) ?
                                   lphd_pkg::MAX_SIZE : CAPACITY;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    B_IDLE,
    B_PROBE
  } bstate_e;

  bstate_e                    state_q;
  bstate_e                    state_d;
  lphd_pkg::action_e          action_q;
  logic [lphd_pkg::KEY_W-1:0] key_q;
  logic [VALUE_BITS-1:0]      val_q;
  logic [IDX_W-1:0]           start_q;
  logic [IDX_W-1:0]           j_q;
  logic [IDX_W-1:0]           j_d;
  logic [SIZE_W-1:0]          n_q;
  logic [DEPTH-1:0]           occ_q;
  logic [SIZE_W-1:0]          count_q;

  logic                       out_valid_q;
  lphd_pkg::status_e          out_status_q;
  logic [lphd_pkg::VALUE_W-1:0] out_value_q;

  logic [lphd_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [VALUE_BITS-1:0]      val_mem [DEPTH];
  logic [lphd_pkg::KEY_W-1:0] key_rd_q;
  logic [VALUE_BITS-1:0]      val_rd_q;

  logic                       can_load;
  logic                       load;
  logic                       wr_en;
  logic                       advance;
  lphd_pkg::status_e          res_status;
  logic [lphd_pkg::VALUE_W-1:0] res_value;
  logic [IDX_W-1:0]           home_idx;
  logic [SIZE_W-1:0]          j_ext;
  logic [IDX_W-1:0]           jn;
  logic                       occ_here;
  logic                       key_hit;

  assign can_load = !out_valid_q || rsp_o.ready;
  assign home_idx = pop_data_i.home[IDX_W-1:0];
  assign j_ext    = SIZE_W'(j_q) + SIZE_W'(1);
  assign jn       = (j_ext >= size_i) ? '0 : j_ext[IDX_W-1:0];
  assign occ_here = occ_q[j_q];
  assign key_hit  = (key_rd_q == key_q);

  // Probe control: classify at pop, then one slot per cycle.
  always_comb begin
    logic done;
    done        = 1'b0;
    pop_ready_o = 1'b0;
    load        = 1'b0;
    wr_en       = 1'b0;
    advance     = 1'b0;
    res_status  = lphd_pkg::ST_OK;
    res_value   = '0;
    state_d     = state_q;
    j_d         = j_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i && can_load) begin
          pop_ready_o = 1'b1;
          j_d         = home_idx;
          if (pop_data_i.refused) begin
            load       = 1'b1;
            res_status = lphd_pkg::ST_ACCESS;
          end else if ((pop_data_i.action == lphd_pkg::ACT_PUT) && (count_q >= size_i)) begin
            load       = 1'b1;
            res_status = lphd_pkg::ST_FULL;
          end else begin
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        if (action_q == lphd_pkg::ACT_PUT) begin
          if (!occ_here) begin
            done       = 1'b1;
            res_status = lphd_pkg::ST_OK;
          end else if (n_q == (size_i - SIZE_W'(1))) begin
            done       = 1'b1;
            res_status = lphd_pkg::ST_FULL;
          end
        end else begin
          if (!occ_here) begin
            done       = 1'b1;
            res_status = lphd_pkg::ST_MISSING;
          end else if (key_hit) begin
            done       = 1'b1;
            res_status = lphd_pkg::ST_OK;
            res_value  = lphd_pkg::VALUE_W'(val_rd_q);
          end else if (jn == start_q) begin
            done       = 1'b1;
            res_status = lphd_pkg::ST_MISSING;
          end
        end
        if (done) begin
          if (can_load) begin
            load    = 1'b1;
            state_d = B_IDLE;
            wr_en   = (action_q == lphd_pkg::ACT_PUT) && (res_status == lphd_pkg::ST_OK);
          end
        end else begin
          advance = 1'b1;
          j_d     = jn;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Control state: probe state, occupancy, entry count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      occ_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        occ_q[j_q] <= 1'b1;
        count_q    <= count_q + SIZE_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (pop_ready_o) begin
      action_q <= pop_data_i.action;
      key_q    <= pop_data_i.key;
      val_q    <= pop_data_i.value[VALUE_BITS-1:0];
      start_q  <= home_idx;
      n_q      <= '0;
    end else if (advance) begin
      n_q <= n_q + SIZE_W'(1);
    end
    if (load) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
    end
  end

  // Slot store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[j_q] <= key_q;
      val_mem[j_q] <= val_q;
    end
    key_rd_q <= key_mem[j_d];
    val_rd_q <= val_mem[j_d];
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.value_out = out_value_q;

endmodule

/* sv/linear_probe_hash_dictionary.sv */
// Top level of the linear probing dictionary: register port and the front, queue and back.
//
// Requests arrive on req_i (valid/ready): action 0 puts key and value_in,
// action 1 gets the value stored under key. Each item gives exactly one result
// item on rsp_o with a status (ok, access refused, table full, not found) and
// value_out, which is non-zero only for a successful get.
// The front end takes an item, hashes the key through three multiply rounds
// and a remainder unit that reduces the high and then the low hash byte, and
// passes it into a two-entry queue; it takes a new item only once the last
// one leaves for the queue, and a refused item skips the hashing. The back
// end probes one slot per cycle through the slot memory and takes no new
// item while it is probing.
// Reset empties every slot and clears the entry count at once; the registers
// return to table_size 256 with reads and writes allowed.
// When the receiver stalls, the result waits in the output register and the
// back end takes no further item until it is accepted; the queue and front end
// fill behind it before req_i.ready falls.
// Registers sit at byte addresses 0, 4 and 8 of the APB port.
module linear_probe_hash_dictionary #(
  parameter int unsigned CAPACITY   = lphd_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = lphd_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lphd_in_if.sink                         req_i,
  lphd_out_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lphd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lphd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lphd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned SIZE_W = lphd_pkg::SIZE_W;
  localparam int unsigned DEPTH  = (CAPACITY > lphd_pkg::MAX_SIZE) ?
                                   lphd_pkg::MAX_SIZE : CAPACITY;

  logic [SIZE_W-1:0]  table_size_q;
  logic               write_allowed_q;
  logic               read_allowed_q;
  logic [SIZE_W-1:0]  size_use;
  logic               cfg_write;
  lphd_pkg::reg_idx_e reg_idx;
  lphd_pkg::cfg_t     cfg;

  logic               push_valid;
  logic               push_ready;
  lphd_pkg::qent_t    push_data;
  logic               pop_valid;
  logic               pop_ready;
  lphd_pkg::qent_t    pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = lphd_pkg::reg_idx_e'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q    <= lphd_pkg::TABLE_SIZE_RST;
      write_allowed_q <= 1'b1;
      read_allowed_q  <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        lphd_pkg::REG_TABLE_SIZE:    table_size_q    <= pwdata[SIZE_W-1:0];
        lphd_pkg::REG_WRITE_ALLOWED: write_allowed_q <= pwdata[0];
        lphd_pkg::REG_READ_ALLOWED:  read_allowed_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      lphd_pkg::REG_TABLE_SIZE:    prdata = lphd_pkg::APB_DATA_W'(table_size_q);
      lphd_pkg::REG_WRITE_ALLOWED: prdata = lphd_pkg::APB_DATA_W'(write_allowed_q);
      lphd_pkg::REG_READ_ALLOWED:  prdata = lphd_pkg::APB_DATA_W'(read_allowed_q);
      default:                     prdata = '0;
    endcase
  end

  // Size in use: zero counts as one slot, and it never exceeds the store.
  always_comb begin
    if (table_size_q == '0) begin
      size_use = SIZE_W'(1);
    end else if (table_size_q > SIZE_W'(DEPTH)) begin
      size_use = SIZE_W'(DEPTH);
    end else begin
      size_use = table_size_q;
    end
  end

  assign cfg.size          = size_use;
  assign cfg.write_allowed = write_allowed_q;
  assign cfg.read_allowed  = read_allowed_q;

  lphd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lphd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lphd_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_use),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o)
  );

endmodule

/* sv/lphd_checker.sv */
// Port-level checker of the dictionary and its bind to the top level.
`include "linear_probe_hash_dictionary_assert.svh"

module lphd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  lphd_in_if.sink    req_i,
  lphd_out_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(lphd_pkg::MAX_INFLIGHT + 1) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(lphd_pkg::MAX_INFLIGHT);

  logic [CNT_W-1:0]             outstanding_q;
  logic                         req_fire;
  logic                         rsp_fire;
  logic                         rsp_stall;
  logic                         rsp_not_ok;
  logic [lphd_pkg::VALUE_W+1:0] rsp_payload;

  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign rsp_stall   = rsp_o.valid && !rsp_o.ready;
  assign rsp_not_ok  = rsp_o.valid && (rsp_o.status != lphd_pkg::ST_OK);
  assign rsp_payload = {rsp_o.status, rsp_o.value_out};

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      outstanding_q <= outstanding_q + CNT_W'(1);
    end else if (rsp_fire && !req_fire) begin
      outstanding_q <= outstanding_q - CNT_W'(1);
    end
  end

  // A stalled result holds its payload.
  `LPHD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_o.valid && $stable(rsp_payload))

  // A result with any status but ok carries a zero value.
  `LPHD_ASSERT_IMPLY(a_value_zero, clk_i, rst_ni, rsp_not_ok, rsp_o.value_out == '0)

  // No result appears without an item waiting for it.
  `LPHD_ASSERT_IMPLY(a_no_orphan, clk_i, rst_ni, rsp_o.valid, outstanding_q != '0)

  // The pipeline never holds more items than it has places for.
  `LPHD_ASSERT_IMPLY(a_inflight_bound, clk_i, rst_ni, 1'b1, outstanding_q <= MAX_CNT)

endmodule

bind linear_probe_hash_dictionary lphd_checker u_lphd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);
